// ----- hdl/cowm_pkg.sv -----
// ----------------------------------------------------------------------------
// cowm_pkg: shared types and constants for the clock offset window maximum
// sample chain depth, index widths, transaction payloads and chain control
// ----------------------------------------------------------------------------
package cowm_pkg;

    localparam int RING_DEPTH = 64;
    localparam int IDX_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_W      = $clog2(RING_DEPTH + 1);

    localparam logic [31:0] WINDOW_RESET = 32'd1000000;
    localparam logic [62:0] MAX63        = {63{1'b1}};

    localparam logic CMD_OBSERVE = 1'b0;
    localparam logic CMD_CONVERT = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [62:0] local_time_us;
        logic [62:0] remote_time_us;
    } t_in_item;

    typedef struct packed {
        logic signed [63:0] max_offset_us;
        logic [62:0]        converted_us;
        logic               has_samples;
        logic               evicted_full;
    } t_out_item;

    typedef struct packed {
        logic [62:0]        local_time_us;
        logic signed [63:0] sample_offset;
    } t_sample;

    typedef struct packed {
        logic             shift;
        logic             load;
        logic [IDX_W-1:0] load_idx;
    } t_chain_ctrl;

endpackage

// ----- hdl/cowm_cell.sv -----
// ----------------------------------------------------------------------------
// cowm_cell: one sample slot of the chain
// loads a new sample, or takes its upper neighbour's sample on a shift
// ----------------------------------------------------------------------------
module cowm_cell (
    input  logic             i_clk,
    input  logic             i_shift,
    input  logic             i_load,
    input  cowm_pkg::t_sample i_new,
    input  cowm_pkg::t_sample i_next,
    output cowm_pkg::t_sample o_sample
);
    import cowm_pkg::*;

    t_sample r_sample;

    // load wins over shift so a full-ring push lands in the top cell
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_sample <= i_new;
        end else if (i_shift) begin
            r_sample <= i_next;
        end
    end

    assign o_sample = r_sample;

endmodule

// ----- hdl/cowm_chain.sv -----
// ----------------------------------------------------------------------------
// cowm_chain: row of sample cells, oldest sample at cell zero
// a shift moves every sample one cell down, cell zero wraps to the top
// ----------------------------------------------------------------------------
module cowm_chain (
    input  logic                  i_clk,
    input  cowm_pkg::t_chain_ctrl i_ctrl,
    input  cowm_pkg::t_sample     i_new,
    output cowm_pkg::t_sample     o_head
);
    import cowm_pkg::*;

    t_sample w_q [RING_DEPTH];

    for (genvar k = 0; k < RING_DEPTH; k++) begin : g_cell
        logic w_load;

        assign w_load = i_ctrl.load && (i_ctrl.load_idx == IDX_W'(k));

        cowm_cell u_cell (
            .i_clk    (i_clk),
            .i_shift  (i_ctrl.shift),
            .i_load   (w_load),
            .i_new    (i_new),
            .i_next   (w_q[(k + 1) % RING_DEPTH]),
            .o_sample (w_q[k])
        );
    end

    assign o_head = w_q[0];

endmodule

// ----- hdl/clock_offset_window_max.sv -----
// ----------------------------------------------------------------------------
// clock_offset_window_max: sliding window maximum of remote minus local offset
// observe transactions store samples, convert transactions map local time
// ----------------------------------------------------------------------------
// usage
//   input channel i_in_valid / o_in_stall / i_in_item, taken when valid and
//   not stalled; one input transaction is in work at a time
//   output channel o_out_valid / i_out_stall / o_out_item, one result per
//   input transaction, held in an output register until taken
//   config: i_cfg_we writes i_cfg_wdata into the window length (us); write
//   only while idle
// latency and throughput
//   observe with a remote time: RING_DEPTH + drops + 2 cycles from accept to
//   result valid, drops being the samples aged out of the window
//   other transactions: RING_DEPTH + 1 cycles
//   the figure is set by the maximum scan, which rotates the whole cell
//   chain past its head once, one cell per cycle
//   the next input is taken once the result sits in the output register
// reset: window back to 1000000 us, chain empty, no result pending
// stall: a result waiting on i_out_stall is held stable; a finished scan waits
//   for the output register to free up before the next input is taken
// ----------------------------------------------------------------------------
module clock_offset_window_max (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [31:0]         i_cfg_wdata,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  cowm_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output cowm_pkg::t_out_item o_out_item
);
    import cowm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DROP = 4'b0010,
        S_SCAN = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    // control state
    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [IDX_W-1:0] r_k, n_k;
    logic [31:0]      r_window;
    logic             r_out_valid, n_out_valid;

    // payload held for the transaction in work
    logic               r_cmd;
    logic [62:0]        r_local;
    logic               r_evict;
    logic signed [63:0] r_best, n_best;
    t_out_item          r_out, n_out;

    t_chain_ctrl w_ctrl;
    t_sample     w_new;
    t_sample     w_head;

    logic               w_in_acc;
    logic               w_out_acc;
    logic               w_push;
    logic               w_full;
    logic [63:0]        w_age;
    logic               w_stale;
    logic               w_k_held;
    logic               w_k_last;
    logic signed [63:0] w_mx;
    logic signed [64:0] w_sum;
    logic [62:0]        w_conv;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_acc  = r_out_valid && !i_out_stall;

    // observe with a remote timestamp pushes a sample
    assign w_push = w_in_acc && (i_in_item.cmd == CMD_OBSERVE)
                    && (i_in_item.remote_time_us != 63'd0);
    assign w_full = (r_count == CNT_W'(RING_DEPTH));

    assign w_new.local_time_us = i_in_item.local_time_us;
    assign w_new.sample_offset = $signed({1'b0, i_in_item.remote_time_us})
                                 - $signed({1'b0, i_in_item.local_time_us});

    // wrapped 64-bit age of the oldest sample against the new local time
    assign w_age   = {1'b0, r_local} - {1'b0, w_head.local_time_us};
    assign w_stale = (r_count > CNT_W'(1)) && (w_age > {32'd0, r_window});

    assign w_k_held = ({{(CNT_W - IDX_W){1'b0}}, r_k} < r_count);
    assign w_k_last = (r_k == IDX_W'(RING_DEPTH - 1));

    // result arithmetic, clamp below zero and saturate above 2^63-1
    assign w_mx   = (r_count == '0) ? 64'sd0 : r_best;
    assign w_sum  = $signed({2'b00, r_local}) + $signed({w_mx[63], w_mx});
    always_comb begin
        if (w_sum[64]) begin
            w_conv = 63'd0;
        end else if (w_sum[63]) begin
            w_conv = MAX63;
        end else begin
            w_conv = w_sum[62:0];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_k         = r_k;
        n_best      = r_best;
        n_out       = r_out;
        n_out_valid = r_out_valid && !w_out_acc;
        w_ctrl      = '0;

        unique case (r_state)
            S_IDLE: begin
                n_k    = '0;
                n_best = 64'sd0;
                if (w_in_acc) begin
                    if (w_push) begin
                        // full ring drops its oldest sample in the same cycle
                        w_ctrl.load     = 1'b1;
                        w_ctrl.shift    = w_full;
                        w_ctrl.load_idx = w_full ? IDX_W'(RING_DEPTH - 1)
                                                 : r_count[IDX_W-1:0];
                        n_count = w_full ? r_count : r_count + CNT_W'(1);
                        n_state = S_DROP;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_DROP: begin
                // age out one sample a cycle
                if (w_stale) begin
                    w_ctrl.shift = 1'b1;
                    n_count      = r_count - CNT_W'(1);
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                // full rotation brings every cell past the head once
                w_ctrl.shift = 1'b1;
                if (w_k_held && ((r_k == '0) || (w_head.sample_offset > r_best))) begin
                    n_best = w_head.sample_offset;
                end
                n_k = r_k + IDX_W'(1);
                if (w_k_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || w_out_acc) begin
                    n_out.max_offset_us = w_mx;
                    n_out.converted_us  = (r_cmd == CMD_CONVERT) ? w_conv : 63'd0;
                    n_out.has_samples   = (r_count != '0);
                    n_out.evicted_full  = r_evict;
                    n_out_valid         = 1'b1;
                    n_state             = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
            r_window    <= WINDOW_RESET;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_window <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_best <= n_best;
        r_out  <= n_out;
        if (w_in_acc) begin
            r_cmd   <= i_in_item.cmd;
            r_local <= i_in_item.local_time_us;
            r_evict <= w_push && w_full;
        end
    end

    cowm_chain u_chain (
        .i_clk  (i_clk),
        .i_ctrl (w_ctrl),
        .i_new  (w_new),
        .o_head (w_head)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // sample count stays within the chain
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(RING_DEPTH))
        else $error("sample count beyond chain depth");

    // an accepted transaction always leaves idle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state != S_IDLE))
        else $error("accepted transaction did not start");

    // scan index steps by one each cycle until the last cell
    a_scan_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) && !w_k_last |=> (r_k == $past(r_k) + IDX_W'(1)))
        else $error("scan index skipped");

    // only a finished scan refills the output register
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_acc && (r_state != S_DONE) |=> !o_out_valid)
        else $error("result appeared without a finished scan");

endmodule
